// ===== hw/rtl/cwru_pkg.sv =====
// Shared types, codes and helpers for the congestion window round update block.
// Depends on nothing; every module of the block imports it.
package cwru_pkg;

   localparam int WIN_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int PHASE_BITS     = 2;

   localparam logic [WIN_BITS-1:0] WIN_MAX          = 16'hFFFF;
   localparam logic [WIN_BITS-1:0] DUP_GAP          = 16'd3;
   localparam logic [WIN_BITS-1:0] RECOVERY_INFLATE = 16'd3;
   localparam logic [WIN_BITS-1:0] AVOID_STEP       = 16'd1;

   localparam logic [WIN_BITS-1:0] RESET_RWND     = 16'd64;
   localparam logic [WIN_BITS-1:0] RESET_TOTAL    = 16'd0;
   localparam logic [WIN_BITS-1:0] RESET_CWND     = 16'd1;
   localparam logic [WIN_BITS-1:0] RESET_SSTHRESH = 16'd64;

   // Phase codes as they appear in the result word.
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_SLOW_START = 2'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_AVOIDANCE  = 2'd1;
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_RECOVERY   = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RWND_LIMIT    = 2'd0,
      CSR_TOTAL_PACKETS = 2'd1,
      CSR_INIT_CWND     = 2'd2,
      CSR_INIT_SSTHRESH = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_SLOW_START = 3'b001,
      PH_AVOIDANCE  = 3'b010,
      PH_RECOVERY   = 3'b100
   } cc_phase_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] round_acks;
      logic [WIN_BITS-1:0] last_ack_seq;
   } req_word_type;

   typedef struct packed {
      logic [WIN_BITS-1:0]   send_start;
      logic [WIN_BITS-1:0]   send_end;
      logic [WIN_BITS-1:0]   window_size;
      logic [PHASE_BITS-1:0] phase;
      logic                  timeout_seen;
      logic                  dup_ack_seen;
      logic [WIN_BITS-1:0]   acked_total;
      logic                  transfer_done;
   } rsp_word_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] rwnd_limit;
      logic [WIN_BITS-1:0] total_packets;
   } cfg_type;

   // Side effects of a write to one of the init registers.
   typedef struct packed {
      logic                cwnd_load;
      logic                ssthresh_load;
      logic [WIN_BITS-1:0] value;
   } csr_load_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] cong_window;
      logic [WIN_BITS-1:0] ssthresh;
      cc_phase_type        phase;
      logic [WIN_BITS-1:0] acked_count;
   } cc_state_type;

   function automatic logic [WIN_BITS-1:0] at_least_one(input logic [WIN_BITS-1:0] v);
      return (v == '0) ? WIN_BITS'(1) : v;
   endfunction

   function automatic logic [WIN_BITS-1:0] sat_add(input logic [WIN_BITS-1:0] a,
                                                   input logic [WIN_BITS-1:0] b);
      logic [WIN_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WIN_BITS] ? WIN_MAX : sum[WIN_BITS-1:0];
   endfunction

   // Sending window: congestion window capped by the receiver window.
   function automatic logic [WIN_BITS-1:0] send_window(input logic [WIN_BITS-1:0] cwnd,
                                                       input logic [WIN_BITS-1:0] rwnd);
      logic [WIN_BITS-1:0] r;
      r = at_least_one(rwnd);
      return (cwnd < r) ? cwnd : r;
   endfunction

endpackage

// ===== hw/rtl/cwru_csr.sv =====
// Configuration registers of the congestion window round update block.
// Depends on cwru_pkg; init writes are passed on as load strobes.
module cwru_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [cwru_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cwru_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output cwru_pkg::cfg_type                    cfg,
   output cwru_pkg::csr_load_type               load
);
   import cwru_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in             = cfg_ff;
      load.cwnd_load     = 1'b0;
      load.ssthresh_load = 1'b0;
      load.value         = at_least_one(csr_data);
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_RWND_LIMIT:    cfg_in.rwnd_limit    = csr_data;
            CSR_TOTAL_PACKETS: cfg_in.total_packets = csr_data;
            CSR_INIT_CWND:     load.cwnd_load       = 1'b1;
            CSR_INIT_SSTHRESH: load.ssthresh_load   = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rwnd_limit    <= RESET_RWND;
         cfg_ff.total_packets <= RESET_TOTAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/cwru_update.sv =====
// Next-state and result logic for one ACK round of the congestion window block.
// Depends on cwru_pkg; purely combinational, sized by SEQ_BITS.
module cwru_update #(
   parameter int SEQ_BITS = 16
) (
   input  logic [SEQ_BITS-1:0]   base_cur,
   input  logic [SEQ_BITS-1:0]   end_cur,
   input  cwru_pkg::cc_state_type cc_cur,
   input  cwru_pkg::cfg_type      cfg,
   input  cwru_pkg::req_word_type req_word,
   output logic [SEQ_BITS-1:0]   base_next,
   output logic [SEQ_BITS-1:0]   end_next,
   output cwru_pkg::cc_state_type cc_next,
   output cwru_pkg::rsp_word_type rsp_word
);
   import cwru_pkg::*;

   // Common width of a sequence value and a 16-bit field.
   localparam int XW    = (SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS;
   // Sum of a sequence value and a 16-bit count; wraps at 32 bits.
   localparam int SUM_W = (SEQ_BITS < WIN_BITS) ? WIN_BITS + 1 :
                          ((SEQ_BITS < 32) ? SEQ_BITS + 1 : 32);

   logic                timeout;
   logic                dup;
   logic [XW-1:0]       seq_wide;
   logic [SEQ_BITS-1:0] seq;
   logic [SEQ_BITS-1:0] expected;
   logic [SEQ_BITS-1:0] received;
   logic [SEQ_BITS-1:0] gap;
   logic [WIN_BITS-1:0] halved;
   logic                acks_ahead;
   logic [WIN_BITS-1:0] win;
   logic [SUM_W-1:0]    end_sum;
   logic [SUM_W-1:0]    end_clip;
   logic [SUM_W-1:0]    acked_sum;
   logic [XW-1:0]       base_wide;
   logic [XW-1:0]       end_wide;

   assign timeout  = (req_word.round_acks == '0);
   assign seq_wide = XW'(req_word.last_ack_seq);
   // A timeout acknowledges nothing: the base stays where it is.
   assign seq      = timeout ? (base_cur - SEQ_BITS'(1)) : seq_wide[SEQ_BITS-1:0];
   assign expected = end_cur - base_cur;
   assign received = seq - base_cur + SEQ_BITS'(1);
   assign gap      = expected - received;
   assign dup      = !timeout && (received <= expected) && (gap >= SEQ_BITS'(DUP_GAP));
   assign halved   = at_least_one({1'b0, cc_cur.cong_window[WIN_BITS-1:1]});
   assign acks_ahead = XW'(req_word.round_acks) > XW'(received);

   always_comb begin
      cc_next = cc_cur;
      if (timeout) begin
         cc_next.ssthresh    = halved;
         cc_next.cong_window = WIN_BITS'(1);
         cc_next.phase       = PH_SLOW_START;
      end else if (dup) begin
         if (cc_cur.phase != PH_RECOVERY) begin
            cc_next.phase       = PH_RECOVERY;
            cc_next.ssthresh    = halved;
            cc_next.cong_window = sat_add(halved, RECOVERY_INFLATE);
         end
      end else begin
         unique case (cc_cur.phase)
            PH_SLOW_START: begin
               cc_next.cong_window = sat_add(cc_cur.cong_window, req_word.round_acks);
            end
            PH_AVOIDANCE: begin
               cc_next.cong_window = sat_add(cc_cur.cong_window, AVOID_STEP);
            end
            PH_RECOVERY: begin
               if (acks_ahead) begin
                  cc_next.cong_window = sat_add(cc_cur.cong_window, req_word.round_acks);
               end else begin
                  // deflate and leave recovery
                  cc_next.cong_window = cc_cur.ssthresh;
                  cc_next.phase       = PH_AVOIDANCE;
               end
            end
            default: ;
         endcase
      end
      if (cc_next.phase == PH_SLOW_START && cc_next.cong_window >= cc_next.ssthresh) begin
         cc_next.phase = PH_AVOIDANCE;
      end

      acked_sum = SUM_W'(cc_cur.acked_count) + SUM_W'(received);
      cc_next.acked_count = (acked_sum > SUM_W'(WIN_MAX)) ? WIN_MAX : acked_sum[WIN_BITS-1:0];
   end

   assign win       = send_window(cc_next.cong_window, cfg.rwnd_limit);
   assign base_next = seq + SEQ_BITS'(1);
   assign end_sum   = SUM_W'(base_next) + SUM_W'(win);
   assign end_clip  = (SUM_W'(cfg.total_packets) < end_sum) ? SUM_W'(cfg.total_packets)
                                                            : end_sum;
   assign end_next  = end_clip[SEQ_BITS-1:0];
   assign base_wide = XW'(base_next);
   assign end_wide  = XW'(end_next);

   always_comb begin
      rsp_word.send_start    = base_wide[WIN_BITS-1:0];
      rsp_word.send_end      = end_wide[WIN_BITS-1:0];
      rsp_word.window_size   = win;
      unique case (cc_next.phase)
         PH_SLOW_START: rsp_word.phase = PHASE_CODE_SLOW_START;
         PH_AVOIDANCE:  rsp_word.phase = PHASE_CODE_AVOIDANCE;
         PH_RECOVERY:   rsp_word.phase = PHASE_CODE_RECOVERY;
         default:       rsp_word.phase = PHASE_CODE_SLOW_START;
      endcase
      rsp_word.timeout_seen  = timeout;
      rsp_word.dup_ack_seen  = dup;
      rsp_word.acked_total   = cc_next.acked_count;
      rsp_word.transfer_done = (cc_next.acked_count >= cfg.total_packets);
   end

endmodule

// ===== hw/rtl/congestion_window_round_update.sv =====
// Top level of the congestion window round update block (Reno-style control).
// Depends on cwru_pkg, cwru_csr and cwru_update.
//
// Each request word summarizes one go-back-N round: the number of ACKs seen
// (zero means the round timed out) and the highest acknowledged sequence.
// The block keeps the window base and end, the congestion window, the slow
// start threshold, the control phase and a running acknowledged count, and
// answers every request word with exactly one response word: new window
// base, window end clipped to total_packets, the sending window
// min(cwnd, rwnd_limit), the phase after the update, timeout and duplicate
// ACK flags, the acknowledged total and a transfer-done flag. A request word
// is captured in an input register; once the response register is free, one
// pass of logic updates the state and loads the response register, so a new
// word is taken every cycle while the response side does not stall, and the
// response word is registered. While a response word is stalled the input
// register still takes one word, then stalls the request side until the
// response register drains. Write the configuration
// registers only while no word is in flight; writing init_cwnd also reloads
// the congestion window and window end, and writing init_ssthresh reloads
// the threshold. SEQ_BITS sets the width of sequence arithmetic; the port
// fields stay 16 bits.
module congestion_window_round_update #(
   parameter int SEQ_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cwru_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cwru_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_write,
   input  logic [cwru_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cwru_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import cwru_pkg::*;

   cfg_type             cfg;
   csr_load_type        load;

   // input register
   logic                req_valid_ff;
   logic                req_valid_in;
   req_word_type        req_word_ff;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_word_type        rsp_word_ff;
   rsp_word_type        rsp_word_calc;

   // round state
   logic [SEQ_BITS-1:0] window_base_ff;
   logic [SEQ_BITS-1:0] window_end_ff;
   cc_state_type        cc_ff;
   logic [SEQ_BITS-1:0] base_calc;
   logic [SEQ_BITS-1:0] end_calc;
   cc_state_type        cc_calc;

   logic                rsp_free;
   logic                fire;
   logic                req_take;

   cwru_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .load      (load)
   );

   cwru_update #(
      .SEQ_BITS (SEQ_BITS)
   ) u_update (
      .base_cur  (window_base_ff),
      .end_cur   (window_end_ff),
      .cc_cur    (cc_ff),
      .cfg       (cfg),
      .req_word  (req_word_ff),
      .base_next (base_calc),
      .end_next  (end_calc),
      .cc_next   (cc_calc),
      .rsp_word  (rsp_word_calc)
   );

   // The response register frees up when empty or drained this cycle; the
   // held word then moves across and updates the state in the same edge.
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign fire         = req_valid_ff && rsp_free;
   assign req_stall    = req_valid_ff && !rsp_free;
   assign req_take     = req_valid && !req_stall;
   assign req_valid_in = req_take || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_word_ff <= req_word;
      end
      if (fire) begin
         rsp_word_ff <= rsp_word_calc;
      end
   end

   // Round state: init writes reload, accepted rounds advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff    <= '0;
         window_end_ff     <= SEQ_BITS'(send_window(RESET_CWND, RESET_RWND));
         cc_ff.cong_window <= RESET_CWND;
         cc_ff.ssthresh    <= RESET_SSTHRESH;
         cc_ff.phase       <= PH_SLOW_START;
         cc_ff.acked_count <= '0;
      end else if (load.cwnd_load || load.ssthresh_load) begin
         if (load.cwnd_load) begin
            cc_ff.cong_window <= load.value;
            window_end_ff     <= window_base_ff
                                 + SEQ_BITS'(send_window(load.value, cfg.rwnd_limit));
         end
         if (load.ssthresh_load) begin
            cc_ff.ssthresh <= load.value;
         end
      end else if (fire) begin
         window_base_ff <= base_calc;
         window_end_ff  <= end_calc;
         cc_ff          <= cc_calc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
